### design/frl_pkg.sv
`timescale 1ns / 1ps

package frl_pkg;

	// operation codes of the func field
	localparam logic [2:0] FN_BEGIN_REC  = 3'd0;
	localparam logic [2:0] FN_REC_FRAME  = 3'd1;
	localparam logic [2:0] FN_END_REC    = 3'd2;
	localparam logic [2:0] FN_BEGIN_PLAY = 3'd3;
	localparam logic [2:0] FN_PLAY_NEXT  = 3'd4;

	localparam int          COUNT_BITS  = 32;
	localparam logic [31:0] COUNT_SAT   = 32'hFFFF_FFFF;
	localparam int          ENTRY_BITS  = 15;
	localparam int          WORD_BITS   = 64;

	typedef struct packed {
		logic [2:0]           func;
		logic [WORD_BITS-1:0] frame_data;
	} cmd_t;

	typedef struct packed {
		logic [WORD_BITS-1:0]  out_frame;
		logic                  frame_valid;
		logic                  is_recording;
		logic                  is_replaying;
		logic                  full_stop;
		logic [ENTRY_BITS-1:0] entry_count;
		logic [COUNT_BITS-1:0] frame_total;
	} rsp_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == COUNT_SAT) ? v : v + 1'b1;
	endfunction

endpackage

### design/frl_table.sv
`timescale 1ns / 1ps

module frl_table #(
	parameter int DEPTH = 16384,
	parameter int WBITS = 64
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic [WBITS-1:0]             rd_word,
	output logic [frl_pkg::COUNT_BITS-1:0] rd_len,
	input  logic                         wr_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  logic [WBITS-1:0]             wr_word,
	input  logic [frl_pkg::COUNT_BITS-1:0] wr_len
);

	// run word and repeat count share one address
	logic [WBITS-1:0]               word_mem [DEPTH];
	logic [frl_pkg::COUNT_BITS-1:0] len_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			word_mem[wr_addr] <= wr_word;
			len_mem[wr_addr]  <= wr_len;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word <= word_mem[rd_addr];
			rd_len  <= len_mem[rd_addr];
		end
	end

endmodule

### design/frl_ctrl.sv
`timescale 1ns / 1ps

module frl_ctrl #(
	parameter int DEPTH = 16384,
	parameter int WBITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  frl_pkg::cmd_t                  cmd,
	output logic                           done,
	output frl_pkg::rsp_t                  rsp,
	output logic                           rd_en,
	output logic [$clog2(DEPTH)-1:0]       rd_addr,
	input  logic [WBITS-1:0]               rd_word,
	input  logic [frl_pkg::COUNT_BITS-1:0] rd_len,
	output logic                           wr_en,
	output logic [$clog2(DEPTH)-1:0]       wr_addr,
	output logic [WBITS-1:0]               wr_word,
	output logic [frl_pkg::COUNT_BITS-1:0] wr_len
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	logic [2:0]       func_s1;
	logic [WBITS-1:0] word_s1;

	logic [CW-1:0]                  stored_q, stored_n;
	logic [WBITS-1:0]               last_word_q, last_word_n;
	logic [frl_pkg::COUNT_BITS-1:0] last_len_q, last_len_n;
	logic                           rec_q, rec_n;
	logic                           play_q, play_n;
	logic [CW-1:0]                  pidx_q, pidx_n;
	logic [frl_pkg::COUNT_BITS-1:0] served_q, served_n;
	logic [frl_pkg::COUNT_BITS-1:0] total_q, total_n;

	logic                           valid_n, full_n;
	logic [frl_pkg::COUNT_BITS-1:0] served_inc;
	logic                           accept;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign rd_en   = accept;
	assign rd_addr = pidx_q[AW-1:0];
	assign served_inc = frl_pkg::sat_inc(served_q);

	always_comb begin
		stored_n    = stored_q;
		last_word_n = last_word_q;
		last_len_n  = last_len_q;
		rec_n       = rec_q;
		play_n      = play_q;
		pidx_n      = pidx_q;
		served_n    = served_q;
		total_n     = total_q;
		valid_n     = 1'b0;
		full_n      = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = stored_q[AW-1:0];
		wr_word     = word_s1;
		wr_len      = frl_pkg::COUNT_BITS'(1);
		case (func_s1)
			frl_pkg::FN_BEGIN_REC: begin
				stored_n    = '0;
				total_n     = '0;
				last_word_n = '0;
				play_n      = 1'b0;
				pidx_n      = '0;
				served_n    = '0;
				rec_n       = 1'b1;
			end
			frl_pkg::FN_REC_FRAME: begin
				if (rec_q) begin
					if ((stored_q != '0) && (word_s1 == last_word_q)) begin
						// repeat of the last run: bump its count in place
						last_len_n = frl_pkg::sat_inc(last_len_q);
						wr_en      = 1'b1;
						wr_addr    = AW'(stored_q - 1'b1);
						wr_word    = last_word_q;
						wr_len     = last_len_n;
						total_n    = frl_pkg::sat_inc(total_q);
					end else if (stored_q == FULL_CNT) begin
						rec_n  = 1'b0;
						full_n = 1'b1;
					end else begin
						wr_en       = 1'b1;
						last_word_n = word_s1;
						last_len_n  = frl_pkg::COUNT_BITS'(1);
						stored_n    = stored_q + 1'b1;
						total_n     = frl_pkg::sat_inc(total_q);
					end
				end
			end
			frl_pkg::FN_END_REC: begin
				rec_n = 1'b0;
			end
			frl_pkg::FN_BEGIN_PLAY: begin
				rec_n    = 1'b0;
				pidx_n   = '0;
				served_n = '0;
				play_n   = (stored_q != '0);
			end
			frl_pkg::FN_PLAY_NEXT: begin
				if (!play_q || (pidx_q >= stored_q)) begin
					play_n = 1'b0;
				end else begin
					valid_n = 1'b1;
					if (served_inc >= rd_len) begin
						pidx_n   = pidx_q + 1'b1;
						served_n = '0;
					end else begin
						served_n = served_inc;
					end
				end
			end
			default: begin
			end
		endcase
		if (state_q != ST_EXEC) begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= cmd.func;
			word_s1 <= cmd.frame_data[WBITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done        <= 1'b0;
			stored_q    <= '0;
			last_word_q <= '0;
			last_len_q  <= '0;
			rec_q       <= 1'b0;
			play_q      <= 1'b0;
			pidx_q      <= '0;
			served_q    <= '0;
			total_q     <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q     <= ST_IDLE;
					done        <= 1'b1;
					stored_q    <= stored_n;
					last_word_q <= last_word_n;
					last_len_q  <= last_len_n;
					rec_q       <= rec_n;
					play_q      <= play_n;
					pidx_q      <= pidx_n;
					served_q    <= served_n;
					total_q     <= total_n;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			rsp.out_frame    <= valid_n ? frl_pkg::WORD_BITS'(rd_word) : '0;
			rsp.frame_valid  <= valid_n;
			rsp.is_recording <= rec_n;
			rsp.is_replaying <= play_n;
			rsp.full_stop    <= full_n;
			rsp.entry_count  <= frl_pkg::ENTRY_BITS'(stored_n);
			rsp.frame_total  <= total_n;
		end
	end

endmodule

### design/frame_run_length_recorder_top.sv
`timescale 1ns / 1ps

// run-length recorder and player for per-frame words. a word is taken when
// start is high and busy is low. its result is on rsp with done high for
// exactly one cycle, once the command has been registered, executed in the
// exec state and its result registered. the result must be taken at the edge
// that ends that cycle, since there is no way to hold it off. busy is high in
// the exec state after each accept, so a new word is not taken until the last
// one has executed; the busy cycle uses the registered read of the run table
// at the current replay position. the run table is not cleared at reset and
// needs no warm-up: replay only ever uses entries that recording has written.
module frame_run_length_recorder_top #(
	parameter int MAX_ENTRIES = 16384,
	parameter int FRAME_BITS  = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  frl_pkg::cmd_t cmd,
	output logic          done,
	output frl_pkg::rsp_t rsp
);

	localparam int AW = $clog2(MAX_ENTRIES);

	// table port signals between controller and run memory
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	logic [FRAME_BITS-1:0]          rd_word;
	logic [frl_pkg::COUNT_BITS-1:0] rd_len;
	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic [FRAME_BITS-1:0]          wr_word;
	logic [frl_pkg::COUNT_BITS-1:0] wr_len;

	// sequencer: holds flags, counters and the open run, builds each result word
	frl_ctrl #(
		.DEPTH(MAX_ENTRIES),
		.WBITS(FRAME_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_word(rd_word),
		.rd_len (rd_len),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_word(wr_word),
		.wr_len (wr_len)
	);

	// run table: word and repeat count per entry, one read and one write port
	frl_table #(
		.DEPTH(MAX_ENTRIES),
		.WBITS(FRAME_BITS)
	) u_table (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_word(rd_word),
		.rd_len (rd_len),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_word(wr_word),
		.wr_len (wr_len)
	);

endmodule
